/* design/slfc_pkg.sv */
// shared constants, phase and status codes, and result type for the frame checker
// no dependencies
package slfc_pkg;

  localparam logic [7:0] SyncFirst    = 8'hB5;
  localparam logic [7:0] SyncSecond   = 8'h62;
  localparam int unsigned FramingBytes = 8;

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_SYNC2 = 8'b0000_0010,
    PH_CLASS = 8'b0000_0100,
    PH_ID    = 8'b0000_1000,
    PH_LENLO = 8'b0001_0000,
    PH_LENHI = 8'b0010_0000,
    PH_BODY  = 8'b0100_0000,
    PH_CKB   = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_DROP  = 2'd2,
    ST_CKERR = 2'd3
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  message_class;
    logic [7:0]  message_id;
    logic        frame_end;
    status_e     frame_status;
    logic [16:0] frame_length;
  } result_t;

endpackage

/* design/slfc_in_stage.sv */
// input register holding one received byte until the parser takes it
// depends on slfc_pkg
module slfc_in_stage import slfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       advance_i,
  output item_t      item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= data_byte_i;
    end
  end

  assign item_o.valid     = valid_q;
  assign item_o.data_byte = byte_q;

endmodule

/* design/slfc_parser.sv */
// frame phase tracking, fletcher sums and per-byte result logic
// depends on slfc_pkg
module slfc_parser import slfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  output result_t    result_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_a_q, rx_a_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  acc_a;
  result_t     res;

  assign acc_a = sum_a_q + data_byte_i;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    rx_a_d  = rx_a_q;
    class_d = class_q;
    id_d    = id_q;
    res     = '0;
    res.frame_status = ST_BUSY;
    case (phase_q)
      PH_HUNT: begin
        if (data_byte_i == SyncFirst) begin
          phase_d = PH_SYNC2;
        end else begin
          res.frame_status = ST_DROP;
        end
      end
      PH_SYNC2: begin
        if (data_byte_i == SyncSecond) begin
          phase_d = PH_CLASS;
        end else begin
          res.frame_status = ST_DROP;
          phase_d = (data_byte_i == SyncFirst) ? PH_SYNC2 : PH_HUNT;
        end
      end
      PH_CLASS: begin
        sum_a_d = data_byte_i;
        sum_b_d = data_byte_i;
        class_d = data_byte_i;
        phase_d = PH_ID;
      end
      PH_ID: begin
        sum_a_d = acc_a;
        sum_b_d = sum_b_q + acc_a;
        id_d    = data_byte_i;
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        sum_a_d = acc_a;
        sum_b_d = sum_b_q + acc_a;
        len_d   = {8'd0, data_byte_i};
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        sum_a_d = acc_a;
        sum_b_d = sum_b_q + acc_a;
        len_d   = {data_byte_i, len_q[7:0]};
        count_d = '0;
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        if (count_q < len_q) begin
          sum_a_d = acc_a;
          sum_b_d = sum_b_q + acc_a;
          res.payload_valid = 1'b1;
          res.payload_byte  = data_byte_i;
          res.payload_index = count_q;
          count_d = count_q + 16'd1;
        end else begin
          rx_a_d  = data_byte_i;
          phase_d = PH_CKB;
        end
      end
      PH_CKB: begin
        res.frame_end    = 1'b1;
        res.frame_status = (rx_a_q == sum_a_q && data_byte_i == sum_b_q) ?
                           ST_GOOD : ST_CKERR;
        res.frame_length = {1'b0, len_q} + 17'(FramingBytes);
        phase_d = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
    res.message_class = class_d;
    res.message_id    = id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      rx_a_q  <= '0;
      class_q <= '0;
      id_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      rx_a_q  <= rx_a_d;
      class_q <= class_d;
      id_q    <= id_d;
    end
  end

  assign result_o = res;

  a_frame_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.frame_end |-> (res.frame_status == ST_GOOD || res.frame_status == ST_CKERR))
    else $error("frame end without final status");

  a_ckb_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_CKB) |=> (phase_q == PH_HUNT))
    else $error("parser did not resume hunting after frame end");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY || phase_q == PH_CKB) |-> (count_q <= len_q))
    else $error("payload count ran past length");

  a_payload_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.payload_valid |-> (phase_q == PH_BODY && !res.frame_end))
    else $error("payload byte outside body phase");

endmodule

/* design/slfc_out_stage.sv */
// result register holding one transaction until the consumer takes it
// depends on slfc_pkg
module slfc_out_stage import slfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

/* design/sync_length_frame_checker_unit.sv */
// Framed byte-stream receiver with 8-bit Fletcher check. Each accepted byte
// yields exactly one result transaction; one byte per cycle is sustained
// unless the result side stalls. Each byte passes the input register, then
// the parser logic into the result register. The parser state updates once
// per byte, so the phase step and the two 8-bit sum adds set the cycle time.
// Depends on slfc_pkg, slfc_in_stage, slfc_parser and slfc_out_stage.
module sync_length_frame_checker_unit import slfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  message_class_o,
  output logic [7:0]  message_id_o,
  output logic        frame_end_o,
  output logic [1:0]  frame_status_o,
  output logic [16:0] frame_length_o
);

  item_t   item;
  result_t res_comb;
  result_t res_out;
  logic    can_load;
  logic    advance;

  assign advance = item.valid && can_load;

  slfc_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .item_o      (item)
  );

  slfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (item.data_byte),
    .result_o    (res_comb)
  );

  slfc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (res_comb),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_out)
  );

  assign payload_valid_o = res_out.payload_valid;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_index_o = res_out.payload_index;
  assign message_class_o = res_out.message_class;
  assign message_id_o    = res_out.message_id;
  assign frame_end_o     = res_out.frame_end;
  assign frame_status_o  = res_out.frame_status;
  assign frame_length_o  = res_out.frame_length;

endmodule

/* tb/slfc_frame_scoreboard_pkg.sv */
// scoreboard for the frame checker: byte-level parser predictor and result compare
// depends on slfc_pkg
`timescale 1ns / 100ps
package slfc_frame_scoreboard_pkg;
  import slfc_pkg::*;

  class frame_scoreboard;
    phase_e      phase;
    logic [15:0] body_count;
    logic [15:0] body_len;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  rx_sum_a;
    logic [7:0]  class_q;
    logic [7:0]  id_q;
    result_t     expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned good_frames;
    int unsigned bad_frames;
    int unsigned dropped;
    int unsigned payload_bytes;

    function new();
      phase         = PH_HUNT;
      body_count    = '0;
      body_len      = '0;
      sum_a         = '0;
      sum_b         = '0;
      rx_sum_a      = '0;
      class_q       = '0;
      id_q          = '0;
      errors        = 0;
      checked       = 0;
      good_frames   = 0;
      bad_frames    = 0;
      dropped       = 0;
      payload_bytes = 0;
    endfunction

    function void add_fletcher(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    // accepted input transaction: step the parser and queue the expected result
    function void note_byte(logic [7:0] b);
      result_t r;
      r = '0;
      case (phase)
        PH_HUNT: begin
          if (b == SyncFirst) begin
            phase = PH_SYNC2;
          end else begin
            r.frame_status = ST_DROP;
          end
        end
        PH_SYNC2: begin
          if (b == SyncSecond) begin
            phase = PH_CLASS;
          end else begin
            r.frame_status = ST_DROP;
            phase = (b == SyncFirst) ? PH_SYNC2 : PH_HUNT;
          end
        end
        PH_CLASS: begin
          sum_a = '0;
          sum_b = '0;
          add_fletcher(b);
          class_q = b;
          phase = PH_ID;
        end
        PH_ID: begin
          add_fletcher(b);
          id_q = b;
          phase = PH_LENLO;
        end
        PH_LENLO: begin
          add_fletcher(b);
          body_len = {8'h00, b};
          phase = PH_LENHI;
        end
        PH_LENHI: begin
          add_fletcher(b);
          body_len[15:8] = b;
          body_count = '0;
          phase = PH_BODY;
        end
        PH_BODY: begin
          if (body_count < body_len) begin
            add_fletcher(b);
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = body_count;
            body_count = body_count + 16'd1;
            payload_bytes++;
          end else begin
            rx_sum_a = b;
            phase = PH_CKB;
          end
        end
        default: begin
          r.frame_end = 1'b1;
          r.frame_status = (rx_sum_a == sum_a && b == sum_b) ? ST_GOOD : ST_CKERR;
          r.frame_length = 17'(body_len) + 17'(FramingBytes);
          if (r.frame_status == ST_GOOD) good_frames++;
          else bad_frames++;
          phase = PH_HUNT;
        end
      endcase
      if (r.frame_status == ST_DROP) dropped++;
      r.message_class = class_q;
      r.message_id = id_q;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void diff(string fld, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, fld, want, got);
      end
    endfunction

    // accepted result transaction: compare with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        checked++;
        diff("payload_valid", want.payload_valid, got.payload_valid);
        diff("payload_byte", want.payload_byte, got.payload_byte);
        diff("payload_index", want.payload_index, got.payload_index);
        diff("message_class", want.message_class, got.message_class);
        diff("message_id", want.message_id, got.message_id);
        diff("frame_end", want.frame_end, got.frame_end);
        diff("frame_status", want.frame_status, got.frame_status);
        diff("frame_length", want.frame_length, got.frame_length);
      end
    endfunction
  endclass

endpackage

/* tb/tb_sync_length_frame_checker_unit.sv */
// top-level testbench for sync_length_frame_checker_unit: directed and random byte
// streams with random idling on both sides; depends on slfc_pkg and slfc_frame_scoreboard_pkg
`timescale 1ns / 100ps
module tb_sync_length_frame_checker_unit;
  import slfc_pkg::*;
  import slfc_frame_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomItems = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  message_class_o;
  logic [7:0]  message_id_o;
  logic        frame_end_o;
  logic [1:0]  frame_status_o;
  logic [16:0] frame_length_o;

  frame_scoreboard sb;
  bit          idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  sync_length_frame_checker_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o(payload_byte_o),
    .payload_index_o(payload_index_o),
    .message_class_o(message_class_o),
    .message_id_o(message_id_o),
    .frame_end_o(frame_end_o),
    .frame_status_o(frame_status_o),
    .frame_length_o(frame_length_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == SyncFirst || b == SyncSecond);
    return b;
  endfunction

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input bit extra_sync,
                            input bit corrupt);
    logic [7:0] hdr[4];
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] pb;
    ca = '0;
    cb = '0;
    hdr = '{cls, id, len[7:0], len[15:8]};
    if (extra_sync) send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    foreach (hdr[k]) begin
      ca = ca + hdr[k];
      cb = cb + ca;
      send_byte(hdr[k]);
    end
    repeat (len) begin
      pb = 8'($urandom);
      ca = ca + pb;
      cb = cb + ca;
      send_byte(pb);
    end
    if (corrupt) begin
      if ($urandom_range(0, 1)) ca = ca ^ 8'($urandom_range(1, 255));
      else cb = cb ^ 8'($urandom_range(1, 255));
    end
    send_byte(ca);
    send_byte(cb);
  endtask

  // line noise that always leaves the parser hunting
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: begin
        send_byte(plain_byte());
      end
      1: begin
        send_byte(SyncSecond);
      end
      2: begin
        send_byte(SyncFirst);
        send_byte(plain_byte());
      end
      default: begin
        send_byte(SyncFirst);
        send_byte(SyncFirst);
        send_byte(plain_byte());
      end
    endcase
  endtask

  initial begin : result_side
    int unsigned idle_left;
    int unsigned hold_left;
    bit          hold_done;
    idle_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 18) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.payload_valid = payload_valid_o;
      got.payload_byte = payload_byte_o;
      got.payload_index = payload_index_o;
      got.message_class = message_class_o;
      got.message_id = message_id_o;
      got.frame_end = frame_end_o;
      got.frame_status = status_e'(frame_status_o);
      got.frame_length = frame_length_o;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // garbage while hunting, broken sync, restart on a repeated sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncSecond);
    send_byte(SyncFirst);
    send_byte(8'h33);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b1, 1'b0);
    send_frame(8'h00, 8'hFF, 16'd1, 1'b0, 1'b1);

    // random part, starting with a long output stall to back up the input
    long_hold_req = 1'b1;
    while (items_sent < RandomItems - 80) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 24)),
                   $urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end

    // back-to-back traffic, ending with a longer frame
    idle_on = 1'b0;
    repeat (4) send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 8)),
                          1'b0, $urandom_range(0, 1));
    send_frame(8'($urandom), 8'($urandom), 16'd24, 1'b0, 1'b0);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d results: %0d payload bytes, %0d dropped",
             items_sent, sb.checked, sb.payload_bytes, sb.dropped);
    $display("frames: %0d good, %0d checksum errors, %0d mismatches",
             sb.good_frames, sb.bad_frames, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
